@@ design/dual_chip_glcd_pixel_set_sequencer_assert.svh @@
// Assertion macros shared by the pixel-set sequencer modules.
`ifndef DUAL_CHIP_GLCD_PIXEL_SET_SEQUENCER_ASSERT_SVH
`define DUAL_CHIP_GLCD_PIXEL_SET_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked on aclk outside reset.
`define GCPS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gcps same-cycle check failed");

// Next-cycle implication, checked on aclk outside reset.
`define GCPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gcps next-cycle check failed");

`endif

@@ design/gcps_pkg.sv @@
// Types, codes and constants of the pixel-set sequencer.
package gcps_pkg;

    localparam logic [1:0] OP_SET_PIXEL = 2'd0;
    localparam logic [1:0] OP_READ_BACK = 2'd1;
    localparam logic [1:0] OP_RAW_CMD   = 2'd2;

    localparam logic [7:0] CMD_SET_COLUMN = 8'h40;
    localparam logic [7:0] CMD_SET_PAGE   = 8'hB8;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [1:0] {
        KIND_PIXEL,
        KIND_MERGE,
        KIND_RAW,
        KIND_REJECT
    } kind_t;

    // Work descriptor handed from front to back.
    // pixel: byte_a = set page, byte_b = set column
    // merge: byte_a = set column, byte_b = merged data byte
    // raw:   byte_a = control byte
    typedef struct packed {
        kind_t      kind;
        logic       chip;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
    } desc_t;

    // Index of the final bus transaction for a descriptor kind.
    function automatic logic [1:0] last_beat(input kind_t kind);
        logic [1:0] n;
        case (kind)
            KIND_PIXEL: n = 2'd3;
            KIND_MERGE: n = 2'd1;
            default:    n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

@@ design/gcps_front.sv @@
// Front end: accepts requests, tracks the pending pixel update, emits descriptors.
module gcps_front
    import gcps_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_op,
    input  logic [7:0] s_x,
    input  logic [7:0] s_y,
    input  logic       s_chip,
    input  logic [7:0] s_cmd_byte,
    input  logic [7:0] s_read_byte,
    input  logic       q_full,
    output logic       q_push,
    output desc_t      q_desc
);

    logic       awaiting_reg, awaiting_next;
    logic       pend_chip_reg, pend_chip_next;
    logic [5:0] pend_col_reg, pend_col_next;
    logic [2:0] pend_bit_reg, pend_bit_next;

    logic  accept;
    logic  emit;
    logic  in_range;
    desc_t desc;

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign in_range = !s_x[7] && (s_y[7:6] == 2'b00);

    always_comb begin
        emit           = 1'b0;
        desc           = '0;
        awaiting_next  = awaiting_reg;
        pend_chip_next = pend_chip_reg;
        pend_col_next  = pend_col_reg;
        pend_bit_next  = pend_bit_reg;
        case (s_op)
            OP_SET_PIXEL: begin
                if (in_range) begin
                    emit = 1'b1;
                    if (awaiting_reg) begin
                        desc.kind = KIND_REJECT;
                    end else begin
                        desc.kind   = KIND_PIXEL;
                        desc.chip   = s_x[6];
                        desc.byte_a = CMD_SET_PAGE | {5'b0, ~s_y[5:3]};
                        desc.byte_b = CMD_SET_COLUMN | {2'b0, s_x[5:0]};
                        if (accept) begin
                            awaiting_next  = 1'b1;
                            pend_chip_next = s_x[6];
                            pend_col_next  = s_x[5:0];
                            pend_bit_next  = ~s_y[2:0];
                        end
                    end
                end
            end
            OP_READ_BACK: begin
                if (awaiting_reg) begin
                    emit        = 1'b1;
                    desc.kind   = KIND_MERGE;
                    desc.chip   = pend_chip_reg;
                    desc.byte_a = CMD_SET_COLUMN | {2'b0, pend_col_reg};
                    desc.byte_b = s_read_byte | (8'd1 << pend_bit_reg);
                    if (accept) begin
                        awaiting_next = 1'b0;
                    end
                end
            end
            OP_RAW_CMD: begin
                emit = 1'b1;
                if (awaiting_reg) begin
                    desc.kind = KIND_REJECT;
                end else begin
                    desc.kind   = KIND_RAW;
                    desc.chip   = s_chip;
                    desc.byte_a = s_cmd_byte;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    assign q_push = accept && emit;
    assign q_desc = desc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            awaiting_reg  <= 1'b0;
            pend_chip_reg <= 1'b0;
            pend_col_reg  <= '0;
            pend_bit_reg  <= '0;
        end else begin
            awaiting_reg  <= awaiting_next;
            pend_chip_reg <= pend_chip_next;
            pend_col_reg  <= pend_col_next;
            pend_bit_reg  <= pend_bit_next;
        end
    end

endmodule

@@ design/gcps_queue.sv @@
// Short descriptor queue between front and back.
module gcps_queue
    import gcps_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  desc_t push_desc,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output desc_t head_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t            slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`include "dual_chip_glcd_pixel_set_sequencer_assert.svh"

    `GCPS_ASSERT_IMPL(a_no_overfill, 1'b1, count_reg <= CNT_W'(DEPTH))
    `GCPS_ASSERT_IMPL(a_no_pop_empty, pop, count_reg != '0)
    `GCPS_ASSERT_NEXT(a_fill_step, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

@@ design/gcps_back.sv @@
// Back end: expands descriptors into bus transactions behind an output register.
module gcps_back
    import gcps_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  desc_t      q_desc,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_bus_chip,
    output logic       m_is_data,
    output logic       m_is_read,
    output logic [7:0] m_bus_byte,
    output logic       m_last,
    output logic       m_rejected
);

    logic [1:0] beat_reg, beat_next;
    logic       valid_reg, valid_next;
    logic       chip_reg, data_reg, read_reg, last_reg, rej_reg;
    logic [7:0] byte_reg;

    logic       load;
    logic       fin;
    logic       b_data, b_read, b_rej;
    logic [7:0] b_byte;

    assign load  = q_valid && (!valid_reg || m_ready);
    assign fin   = (beat_reg == last_beat(q_desc.kind));
    assign q_pop = load && fin;

    always_comb begin
        beat_next  = beat_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            beat_next  = fin ? 2'd0 : beat_reg + 2'd1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    // Transaction fields for the current beat of the head descriptor.
    always_comb begin
        b_data = 1'b0;
        b_read = 1'b0;
        b_rej  = 1'b0;
        b_byte = 8'd0;
        case (q_desc.kind)
            KIND_PIXEL: begin
                case (beat_reg)
                    2'd0:    b_byte = q_desc.byte_a;
                    2'd1:    b_byte = q_desc.byte_b;
                    default: begin
                        b_data = 1'b1;
                        b_read = 1'b1;
                    end
                endcase
            end
            KIND_MERGE: begin
                if (beat_reg == 2'd0) begin
                    b_byte = q_desc.byte_a;
                end else begin
                    b_data = 1'b1;
                    b_byte = q_desc.byte_b;
                end
            end
            KIND_RAW: begin
                b_byte = q_desc.byte_a;
            end
            default: begin
                b_rej = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            beat_reg  <= beat_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            chip_reg <= b_rej ? 1'b0 : q_desc.chip;
            data_reg <= b_data;
            read_reg <= b_read;
            byte_reg <= b_byte;
            last_reg <= fin;
            rej_reg  <= b_rej;
        end
    end

    assign m_valid    = valid_reg;
    assign m_bus_chip = chip_reg;
    assign m_is_data  = data_reg;
    assign m_is_read  = read_reg;
    assign m_bus_byte = byte_reg;
    assign m_last     = last_reg;
    assign m_rejected = rej_reg;

`include "dual_chip_glcd_pixel_set_sequencer_assert.svh"

    // mid-expansion the descriptor must still sit at the queue head
    `GCPS_ASSERT_IMPL(a_head_held, beat_reg != 2'd0, q_valid)
    `GCPS_ASSERT_IMPL(a_reject_shape, valid_reg && rej_reg,
        last_reg && !chip_reg && !data_reg && !read_reg && byte_reg == 8'd0)
    `GCPS_ASSERT_NEXT(a_pop_marks_last, q_pop, valid_reg && last_reg)

endmodule

@@ design/dual_chip_glcd_pixel_set_sequencer.sv @@
// Pixel-set sequencer for a two-chip 128x64 panel: top level.
// Input channel (s_*): one request per transfer; s_op selects set pixel,
// read byte returned from the panel, or raw control write.
// Output channel (m_*): one bus transaction per transfer; m_last marks the
// final transaction of a request, m_rejected a refused request.
// A set pixel yields four transactions (set page, set column, dummy read,
// read); the matching read-back yields set column and the merged data write.
// Out-of-range pixels, stray read-backs and unused op codes yield nothing.
// The first transaction of a request is presented from the output register,
// after its descriptor has passed through the descriptor queue.
// Throughput: the back end issues one transaction per cycle while m_ready
// is high; a raw write or a refusal yields a single transaction.
// The front keeps accepting while the descriptor queue (QUEUE_DEPTH entries)
// has room, also while a result waits at the output.
// When the receiver stalls, the output register holds its transaction and
// the queue fills, then s_ready drops.
// Reset (aresetn low, synchronous) empties the queue and the output and
// clears the pending pixel update.
module dual_chip_glcd_pixel_set_sequencer
    import gcps_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_op,
    input  logic [7:0] s_x,
    input  logic [7:0] s_y,
    input  logic       s_chip,
    input  logic [7:0] s_cmd_byte,
    input  logic [7:0] s_read_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_bus_chip,
    output logic       m_is_data,
    output logic       m_is_read,
    output logic [7:0] m_bus_byte,
    output logic       m_last,
    output logic       m_rejected
);

    logic  q_full, q_push, q_pop, q_valid;
    desc_t q_in, q_head;

    gcps_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_x         (s_x),
        .s_y         (s_y),
        .s_chip      (s_chip),
        .s_cmd_byte  (s_cmd_byte),
        .s_read_byte (s_read_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_desc      (q_in)
    );

    gcps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_desc  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_desc  (q_head)
    );

    gcps_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_desc     (q_head),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_bus_chip (m_bus_chip),
        .m_is_data  (m_is_data),
        .m_is_read  (m_is_read),
        .m_bus_byte (m_bus_byte),
        .m_last     (m_last),
        .m_rejected (m_rejected)
    );

endmodule
